// ----- hw/rtl/pbn_pkg.sv -----
// ----------------------------------------------------------------------------
// Palette blend package
// Command and status types shared by the controller and the datapath of the
// palette blend and nearest color block.
// ----------------------------------------------------------------------------
package pbn_pkg;

	localparam int CH_W  = 8;
	localparam int RGB_W = 3 * CH_W;
	localparam int SQ_W  = 2 * CH_W;
	localparam int DIST_W = SQ_W + 2;

	// Rounding term and full-scale alpha of the blend.
	localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;
	localparam logic [CH_W-1:0] BLEND_RND = 8'd127;

	// Palette read port address sources.
	localparam logic [1:0] RD_BG    = 2'd0;
	localparam logic [1:0] RD_FG    = 2'd1;
	localparam logic [1:0] RD_ENTRY = 2'd2;
	localparam logic [1:0] RD_SCAN  = 2'd3;

	// Result sources.
	localparam logic [1:0] RES_WRITE = 2'd0;
	localparam logic [1:0] RES_BG    = 2'd1;
	localparam logic [1:0] RES_FG    = 2'd2;
	localparam logic [1:0] RES_NEAR  = 2'd3;

	typedef logic [RGB_W-1:0] rgb_t;

	typedef struct packed {
		logic       load;
		logic       bg_load;
		logic       mix_load;
		logic       mem_we;
		logic       scan_clr;
		logic       scan_step;
		logic       out_load;
		logic [1:0] rd_sel;
		logic [1:0] res_sel;
	} pbn_cmd_t;

	typedef struct packed {
		logic is_write;
		logic wr_ok;
		logic take_bg;
		logic take_fg;
		logic scan_last;
	} pbn_status_t;

endpackage

// ----- hw/rtl/pbn_dp.sv -----
// ----------------------------------------------------------------------------
// Palette blend datapath
// Holds the palette memory, the per-channel blend and the pipelined
// distance scan that tracks the nearest entry.
// ----------------------------------------------------------------------------
module pbn_dp #(
	parameter int NUM_COLORS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pbn_pkg::pbn_cmd_t    cmd,
	output pbn_pkg::pbn_status_t status,
	input  logic                 func,
	input  logic [7:0]           background,
	input  logic [7:0]           foreground,
	input  logic [7:0]           alpha,
	input  logic [3:0]           entry_index,
	input  logic [23:0]          entry_rgb,
	output logic [7:0]           color_index,
	output logic                 palette_changed
);
	import pbn_pkg::*;

	localparam int IW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
	localparam logic [8:0] NC = 9'(NUM_COLORS);
	localparam logic [IW-1:0] LAST = IW'(NUM_COLORS - 1);

	// Latched transaction fields.
	logic            func_q;
	logic [7:0]      bg_q;
	logic [7:0]      fg_q;
	logic [7:0]      alpha_q;
	logic [3:0]      eidx_q;
	rgb_t            rgb_q;
	logic            chg_q;

	// Palette memory with one valid bit per entry.
	rgb_t            mem_q [NUM_COLORS];
	logic [NUM_COLORS-1:0] valid_q;
	rgb_t            rd_data_q;
	logic            rd_vld_q;
	rgb_t            rd_rgb;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	logic [8:0]      eidx_ext;
	logic            changed;

	// Blend.
	rgb_t            bg_rgb_q;
	logic [7:0]      inv_alpha;
	logic [15:0]     pbg_q [3];
	logic [15:0]     pfg_q [3];
	logic [16:0]     mix_sum [3];
	logic [16:0]     mix_adj [3];
	logic [7:0]      mix_q [3];

	// Distance scan.
	logic [IW-1:0]   scan_cnt_q;
	logic            s1_vld_q;
	logic [IW-1:0]   idx_s1;
	logic [8:0]      diff [3];
	logic [8:0]      diff_neg [3];
	logic [7:0]      diff_abs [3];
	logic [15:0]     sq [3];
	logic            s2_vld_q;
	logic [IW-1:0]   idx_s2;
	logic [15:0]     sq_s2 [3];
	logic [DIST_W-1:0] dist_sum;
	logic [DIST_W-1:0] best_dist_q;
	logic [IW-1:0]   best_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			bg_q    <= background;
			fg_q    <= foreground;
			alpha_q <= alpha;
			eidx_q  <= entry_index;
			rgb_q   <= entry_rgb;
		end
		if (cmd.load) begin
			chg_q <= 1'b0;
		end else if (cmd.mem_we) begin
			chg_q <= changed;
		end
	end

	assign eidx_ext = {5'd0, eidx_q};
	assign wr_addr  = eidx_ext[IW-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_BG:    rd_addr = bg_q[IW-1:0];
			RD_FG:    rd_addr = fg_q[IW-1:0];
			RD_ENTRY: rd_addr = wr_addr;
			RD_SCAN:  rd_addr = scan_cnt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[wr_addr] <= rgb_q;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.mem_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// An entry never written since reset reads as black.
	assign rd_rgb  = rd_vld_q ? rd_data_q : '0;
	assign changed = (rd_rgb != rgb_q);

	// Blend: products are registered, then the rounded divide by 255 is done
	// with a shift-add that is exact over the product range.
	assign inv_alpha = ALPHA_MAX - alpha_q;

	always_ff @(posedge clk) begin
		if (cmd.bg_load) begin
			bg_rgb_q <= rd_rgb;
		end
		if (cmd.mix_load) begin
			for (int c = 0; c < 3; c++) begin
				pbg_q[c] <= 16'(bg_rgb_q[CH_W*c +: CH_W]) * 16'(inv_alpha);
				pfg_q[c] <= 16'(rd_rgb[CH_W*c +: CH_W]) * 16'(alpha_q);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix_sum[c] = 17'(pbg_q[c]) + 17'(pfg_q[c]) + 17'(BLEND_RND);
			mix_adj[c] = mix_sum[c] + 17'(mix_sum[c][16:8]) + 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			mix_q[c] <= mix_adj[c][15:8];
		end
	end

	// Scan address counter and pipeline tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			s1_vld_q   <= 1'b0;
			s2_vld_q   <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			s1_vld_q <= cmd.scan_step;
			s2_vld_q <= s1_vld_q;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c]     = {1'b0, mix_q[c]} - {1'b0, rd_rgb[CH_W*c +: CH_W]};
			diff_neg[c] = 9'd0 - diff[c];
			diff_abs[c] = diff[c][8] ? diff_neg[c][7:0] : diff[c][7:0];
			sq[c]       = 16'(diff_abs[c]) * 16'(diff_abs[c]);
		end
	end

	assign dist_sum = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q;
		idx_s2 <= idx_s1;
		for (int c = 0; c < 3; c++) begin
			sq_s2[c] <= sq[c];
		end
		// Strict compare keeps the lowest index among equal distances.
		if (cmd.scan_clr) begin
			best_dist_q <= '1;
		end else if (s2_vld_q && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.res_sel)
				RES_WRITE: begin
					color_index     <= '0;
					palette_changed <= chg_q;
				end
				RES_BG: begin
					color_index     <= bg_q;
					palette_changed <= 1'b0;
				end
				RES_FG: begin
					color_index     <= fg_q;
					palette_changed <= 1'b0;
				end
				RES_NEAR: begin
					color_index     <= 8'(best_idx_q);
					palette_changed <= 1'b0;
				end
			endcase
		end
	end

	assign status.is_write  = !func_q;
	assign status.wr_ok     = eidx_ext < NC;
	assign status.take_bg   = (alpha_q == '0) || ({1'b0, fg_q} >= NC);
	assign status.take_fg   = (alpha_q == ALPHA_MAX) || ({1'b0, bg_q} >= NC);
	assign status.scan_last = (scan_cnt_q == LAST);

endmodule

// ----- hw/rtl/pbn_ctrl.sv -----
// ----------------------------------------------------------------------------
// Palette blend controller
// Sequences one transaction at a time through the datapath and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module pbn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pbn_pkg::pbn_cmd_t    cmd,
	input  pbn_pkg::pbn_status_t status
);
	import pbn_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_WRITE    = 4'd2;
	localparam logic [3:0] S_RD_FG    = 4'd3;
	localparam logic [3:0] S_MIX      = 4'd4;
	localparam logic [3:0] S_SCAN     = 4'd5;
	localparam logic [3:0] S_DRAIN1   = 4'd6;
	localparam logic [3:0] S_DRAIN2   = 4'd7;
	localparam logic [3:0] S_RESULT   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] sel_q;
	logic [1:0] sel_d;
	logic       out_vld_q;

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = RD_SCAN;
		cmd.res_sel = sel_q;
		state_d     = state_q;
		sel_d       = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (status.is_write) begin
					sel_d = RES_WRITE;
					if (status.wr_ok) begin
						cmd.rd_sel = RD_ENTRY;
						state_d    = S_WRITE;
					end else begin
						state_d = S_RESULT;
					end
				end else if (status.take_bg) begin
					sel_d   = RES_BG;
					state_d = S_RESULT;
				end else if (status.take_fg) begin
					sel_d   = RES_FG;
					state_d = S_RESULT;
				end else begin
					cmd.rd_sel = RD_BG;
					sel_d      = RES_NEAR;
					state_d    = S_RD_FG;
				end
			end
			S_WRITE: begin
				cmd.mem_we = 1'b1;
				state_d    = S_RESULT;
			end
			S_RD_FG: begin
				cmd.bg_load = 1'b1;
				cmd.rd_sel  = RD_FG;
				state_d     = S_MIX;
			end
			S_MIX: begin
				cmd.mix_load = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_DRAIN1;
				end
			end
			S_DRAIN1: begin
				state_d = S_DRAIN2;
			end
			S_DRAIN2: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_vld_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= RES_WRITE;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sel_q     <= sel_d;
			out_vld_q <= cmd.out_load | (out_vld_q & result_stall);
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_vld_q;

endmodule

// ----- hw/rtl/palette_blend_nearest_color.sv -----
// ----------------------------------------------------------------------------
// Palette blend with nearest color search
// Keeps a small RGB palette, updates entries and maps an alpha blend of two
// entries back to the nearest palette index.
// ----------------------------------------------------------------------------
// The block works on one transaction at a time and holds item_stall high from
// acceptance until the result is placed in the output register, which keeps a
// finished result while the next transaction is taken. The blend query time is
// set by the distance scan, which reads one palette entry per cycle through the
// single read port of the palette memory. The palette is black after reset at
// once; per-entry valid bits stand in for a clearing pass, so there is no
// startup delay.
module palette_blend_nearest_color #(
	parameter int NUM_COLORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  background,
	input  logic [7:0]  foreground,
	input  logic [7:0]  alpha,
	input  logic [3:0]  entry_index,
	input  logic [23:0] entry_rgb,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  color_index,
	output logic        palette_changed
);
	import pbn_pkg::*;

	// Commands from the controller and status back from the datapath.
	pbn_cmd_t    cmd;
	pbn_status_t status;

	// The controller decides each transaction's path: in-range writes read the old
	// entry, then store the new one, other writes and trivial queries go straight
	// to the result, and blend queries read both entries, mix them and scan.
	pbn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	// The datapath holds the palette, the blend arithmetic, the pipelined
	// distance compare and the result payload register.
	pbn_dp #(
		.NUM_COLORS (NUM_COLORS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.func            (func),
		.background      (background),
		.foreground      (foreground),
		.alpha           (alpha),
		.entry_index     (entry_index),
		.entry_rgb       (entry_rgb),
		.color_index     (color_index),
		.palette_changed (palette_changed)
	);

endmodule

// ----- hw/rtl/pbn_checker.sv -----
// ----------------------------------------------------------------------------
// Palette blend port checker
// Watches the ports of the palette blend block and flags behavior that the
// block must never show.
// ----------------------------------------------------------------------------
module pbn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] color_index,
	input logic       palette_changed
);

	// A stalled result stays in place until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
		(result_valid && $stable(color_index) && $stable(palette_changed)))
		else $error("stalled result changed or dropped");

	// The block is busy right after it takes a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input not stalled after a transaction was accepted");

	// A new result only appears while a transaction is in progress.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared with no transaction in progress");

	// A changed palette entry can only come from a write, which reports index zero.
	a_write_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && palette_changed) |-> (color_index == 8'd0))
		else $error("write result carries a nonzero index");

endmodule

bind palette_blend_nearest_color pbn_checker u_pbn_checker (.*);

// ----- dv/palette_blend_nearest_color_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette blend nearest color testbench
// Drives palette writes and blend queries through the item channel, predicts
// every result from a private copy of the palette and checks each result
// transaction in order, with random idle gaps on both channels in some phases.
// ----------------------------------------------------------------------------
import pbn_pkg::*;

// Expected result of one input transaction.
typedef struct {
	logic [7:0] index;
	logic       changed;
} blend_result_t;

// Shadow palette plus the queue of results still owed by the block.
class blend_scoreboard;
	rgb_t          palette_color [16];
	blend_result_t awaited [$];
	int            errors;

	function new();
		foreach (palette_color[i]) palette_color[i] = '0;
		errors = 0;
	endfunction

	// Rounded alpha mix of one 8-bit channel.
	function automatic int unsigned mix_channel(int unsigned bg, int unsigned fg,
			int unsigned a);
		return (bg * (ALPHA_MAX - a) + fg * a + BLEND_RND) / ALPHA_MAX;
	endfunction

	function automatic logic [7:0] nearest_index(logic [7:0] bgi, logic [7:0] fgi,
			logic [7:0] a);
		int unsigned mix [3];
		int unsigned best_dist;
		int unsigned distance;
		int          d;
		logic [7:0]  best;
		if (a == 8'd0 || fgi >= 16) return bgi;
		if (a == ALPHA_MAX || bgi >= 16) return fgi;
		for (int c = 0; c < 3; c++)
			mix[c] = mix_channel(palette_color[bgi][8*c +: 8],
				palette_color[fgi][8*c +: 8], a);
		best_dist = 32'hFFFF_FFFF;
		best = bgi;
		for (int i = 0; i < 16; i++) begin
			distance = 0;
			for (int c = 0; c < 3; c++) begin
				d = int'(mix[c]) - int'(palette_color[i][8*c +: 8]);
				distance += d * d;
			end
			// Strict compare keeps the lowest index among equal distances.
			if (distance < best_dist) begin
				best_dist = distance;
				best = i[7:0];
			end
		end
		return best;
	endfunction

	function void note_item(logic f, logic [7:0] bgi, logic [7:0] fgi, logic [7:0] a,
			logic [3:0] ei, rgb_t rgb);
		blend_result_t r;
		if (!f) begin
			r.index = 8'd0;
			r.changed = (palette_color[ei] != rgb);
			palette_color[ei] = rgb;
		end else begin
			r.index = nearest_index(bgi, fgi, a);
			r.changed = 1'b0;
		end
		awaited.push_back(r);
	endfunction

	function void check_result(logic [7:0] idx, logic chg);
		blend_result_t r;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result color_index=%0d palette_changed=%0d",
				$time, idx, chg);
			errors++;
			return;
		end
		r = awaited.pop_front();
		if (idx !== r.index) begin
			$display("%0t: color_index expected %0d actual %0d", $time, r.index, idx);
			errors++;
		end
		if (chg !== r.changed) begin
			$display("%0t: palette_changed expected %0d actual %0d",
				$time, r.changed, chg);
			errors++;
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module palette_blend_nearest_color_test;

	localparam int PALETTE_SIZE = 16;
	// A full query plus a long sender gap and a long receiver stall
	// stay well inside the limit, which leaves a wide margin.
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1430;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        func;
	logic [7:0]  background;
	logic [7:0]  foreground;
	logic [7:0]  alpha;
	logic [3:0]  entry_index;
	logic [23:0] entry_rgb;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  color_index;
	logic        palette_changed;

	blend_scoreboard sb;

	// When clear, both channels run back to back with no idle cycles.
	bit idle_on;
	int quiet_cycles;

	palette_blend_nearest_color #(
		.NUM_COLORS(PALETTE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.background(background),
		.foreground(foreground),
		.alpha(alpha),
		.entry_index(entry_index),
		.entry_rgb(entry_rgb),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.color_index(color_index),
		.palette_changed(palette_changed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Presents one input transaction and returns at the edge that accepts it.
	// The prediction is taken at that same edge so that the shadow palette
	// follows the block's own order of writes and queries.
	task automatic send_item(input logic f, input logic [7:0] bgi, input logic [7:0] fgi,
			input logic [7:0] a, input logic [3:0] ei, input logic [23:0] rgb);
		int gap;
		gap = idle_on ? idle_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		func        <= f;
		background  <= bgi;
		foreground  <= fgi;
		alpha       <= a;
		entry_index <= ei;
		entry_rgb   <= rgb;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(f, bgi, fgi, a, ei, rgb);
	endtask

	task automatic write_entry(input logic [3:0] ei, input logic [23:0] rgb);
		send_item(1'b0, 8'd0, 8'd0, 8'd0, ei, rgb);
	endtask

	task automatic blend_query(input logic [7:0] bgi, input logic [7:0] fgi,
			input logic [7:0] a);
		send_item(1'b1, bgi, fgi, a, 4'd0, 24'd0);
	endtask

	// One random palette write. Colors are often copies or near copies of
	// entries already stored, so that ties and close calls come up in the
	// distance scan; rewriting the same value checks the unchanged flag.
	task automatic random_write();
		logic [3:0]  ei;
		logic [23:0] rgb;
		ei = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 4))
			0, 1: rgb = 24'($urandom());
			2: rgb = sb.palette_color[$urandom_range(0, 15)];
			3: rgb = sb.palette_color[$urandom_range(0, 15)] ^ (24'd1 << $urandom_range(0, 23));
			default: begin
				case ($urandom_range(0, 5))
					0: rgb = 24'h000000;
					1: rgb = 24'hFFFFFF;
					2: rgb = 24'hFF0000;
					3: rgb = 24'h00FF00;
					4: rgb = 24'h0000FF;
					default: rgb = sb.palette_color[ei];
				endcase
			end
		endcase
		send_item(1'b0, 8'($urandom()), 8'($urandom()), 8'($urandom()), ei, rgb);
	endtask

	// One random blend query. Indices mostly land inside the palette so the
	// full blend and scan runs; a tenth span all byte values for the bypass paths.
	task automatic random_query();
		logic [7:0] bgi;
		logic [7:0] fgi;
		logic [7:0] a;
		bgi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 15));
		fgi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: a = 8'd0;
			1: a = ALPHA_MAX;
			2: a = 8'($urandom_range(1, 3));
			3: a = 8'($urandom_range(252, 254));
			default: a = 8'($urandom_range(0, 255));
		endcase
		send_item(1'b1, bgi, fgi, a, 4'($urandom()), 24'($urandom()));
	endtask

	// Stimulus and end of run.
	initial begin
		sb = new();
		idle_on = 1'b0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		func         <= 1'b0;
		background   <= 8'd0;
		foreground   <= 8'd0;
		alpha        <= 8'd0;
		entry_index  <= 4'd0;
		entry_rgb    <= 24'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The palette is black after reset, so the first
		// query ties on every entry and must return index zero.
		blend_query(8'd3, 8'd5, 8'd100);
		write_entry(4'd0, 24'h000000);
		write_entry(4'd1, 24'hFFFFFF);
		write_entry(4'd2, 24'hFF0000);
		write_entry(4'd3, 24'h00FF00);
		write_entry(4'd4, 24'h0000FF);
		write_entry(4'd15, 24'h808080);
		write_entry(4'd15, 24'h808080);
		write_entry(4'd15, 24'h818080);
		idle_on = 1'b1;
		// Half way between black and white lands next to the gray entry.
		blend_query(8'd0, 8'd1, 8'd128);
		// Transparent alpha returns the background, even out of range.
		blend_query(8'd200, 8'd255, 8'd0);
		blend_query(8'd2, 8'd3, 8'd0);
		// A foreground out of range beats the opaque rule.
		blend_query(8'd255, 8'd250, ALPHA_MAX);
		blend_query(8'd2, 8'd3, ALPHA_MAX);
		// A background out of range returns the foreground.
		blend_query(8'd255, 8'd4, 8'd100);
		blend_query(8'd4, 8'd16, 8'd100);
		blend_query(8'd2, 8'd4, 8'd1);
		blend_query(8'd2, 8'd4, 8'd254);
		// A second red entry ties with entry two, which must win.
		write_entry(4'd5, 24'hFF0000);
		blend_query(8'd5, 8'd4, 8'd1);
		write_entry(4'd14, 24'h55AA55);
		write_entry(4'd13, 24'hAA55AA);
		blend_query(8'd13, 8'd14, 8'd128);
		write_entry(4'd0, 24'hFFFFFF);

		// Random part, in phases that each pick at random between idle gaps on both
		// channels and back to back traffic.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 160 == 0) idle_on = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 99) < 35) random_write();
			else random_query();
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Receiver: holds result_stall for random stretches, or never while the
	// idle phases are off.
	initial begin
		int n;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = idle_on ? idle_len() : 0;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat (idle_on ? $urandom_range(1, 6) : 8) @(posedge clk);
		end
	end

	// Every accepted result transaction is checked against the oldest
	// prediction. Values sampled here are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(color_index, palette_changed);
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
